/* rtl/tofd_pkg.sv */
// ----------------------------------------------------------------------------
// tofd_pkg
// Shared types, codes and helpers of the out-of-band frame deframer.
// ----------------------------------------------------------------------------
package tofd_pkg;

   localparam logic [7:0] IAC_BYTE = 8'hFF;
   localparam logic [7:0] CHAR_R   = 8'h52;
   localparam logic [7:0] CHAR_S   = 8'h53;
   localparam logic [7:0] CHAR_P   = 8'h50;
   localparam logic [7:0] CHAR_A   = 8'h41;
   localparam logic [7:0] CHAR_F   = 8'h46;
   localparam logic [7:0] CHAR_0   = 8'h30;
   localparam logic [7:0] CHAR_9   = 8'h39;

   // result kinds
   localparam logic [1:0] KIND_CONSOLE = 2'd0;
   localparam logic [1:0] KIND_ROOM    = 2'd1;
   localparam logic [1:0] KIND_SEAT    = 2'd2;
   localparam logic [1:0] KIND_ENTRY   = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_START_MARKER = 2'd0;
   localparam logic [1:0] CSR_END_MARKER   = 2'd1;
   localparam logic [1:0] CSR_DRAIN_LIMIT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_HDR  = 3'b010,
      ST_NAME = 3'b100
   } dec_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [2:0] seat;
      logic [15:0] room;
      logic       name_present;
      logic       last;
   } result_type;

   typedef struct packed {
      logic emit;
      logic busy;
   } dec_stat_type;

   // {ok, value}: 0-9 and upper-case A-F only
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = 8'd0;
         if (c >= CHAR_0 && c <= CHAR_9) begin
            d = c - CHAR_0;
            hex_nibble = {1'b1, d[3:0]};
         end else if (c >= CHAR_A && c <= CHAR_F) begin
            d = c - CHAR_A + 8'd10;
            hex_nibble = {1'b1, d[3:0]};
         end else begin
            hex_nibble = 5'd0;
         end
      end
   endfunction

endpackage

/* rtl/tofd_ram.sv */
// ----------------------------------------------------------------------------
// tofd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tofd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tofd_decoder.sv */
// ----------------------------------------------------------------------------
// tofd_decoder
// Walks a captured frame in the buffer RAM and produces its result beats.
// ----------------------------------------------------------------------------
module tofd_decoder #(
   parameter int FRAME_MAX = 32,
   parameter int NAME_MAX  = 16,
   parameter int SEATS     = 8,
   parameter int LW        = $clog2(FRAME_MAX + 1),
   parameter int AW        = $clog2(FRAME_MAX)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [LW-1:0]           length,
   input  logic                    can_emit,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  logic [7:0]              rd_data,
   output tofd_pkg::dec_stat_type  stat,
   output tofd_pkg::result_type    res
);
   import tofd_pkg::*;

   localparam int CMAX = (FRAME_MAX > NAME_MAX) ? FRAME_MAX : NAME_MAX;
   localparam int CW   = $clog2(CMAX + 1);

   dec_state_type state_ff, state_in;
   logic [2:0]    idx_ff, idx_in;
   logic [1:0]    form_ff, form_in;
   logic [15:0]   room_ff, room_in;
   logic [2:0]    seat_ff, seat_in;
   logic [LW-1:0] len_ff, len_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] em_idx_ff, em_idx_in;

   logic [4:0]    hx;
   logic [7:0]    sdiff;
   logic          sok;
   logic [CW-1:0] avail;
   logic [CW-1:0] ncount;
   logic          pending;
   logic          fire;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      form_in   = form_ff;
      room_in   = room_ff;
      seat_in   = seat_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      rd_idx_in = rd_idx_ff;
      em_idx_in = em_idx_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      stat.emit = 1'b0;
      stat.busy = state_ff != ST_IDLE;
      res       = '0;

      hx      = hex_nibble(rd_data);
      sdiff   = rd_data - CHAR_0;
      sok     = (rd_data >= CHAR_0) && (sdiff < 8'(SEATS));
      avail   = CW'(len_ff - LW'(6));
      ncount  = (avail > CW'(NAME_MAX - 1)) ? CW'(NAME_MAX - 1) : avail;
      pending = rd_idx_ff != em_idx_ff;
      fire    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               len_in   = length;
               idx_in   = 3'd0;
               rd_en    = 1'b1;
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_ff + 3'd1);
            idx_in  = idx_ff + 3'd1;
            if (idx_ff == 3'd0) begin
               if (len_ff == LW'(5) && rd_data == CHAR_R) begin
                  form_in = KIND_ROOM;
               end else if (len_ff == LW'(2) && rd_data == CHAR_S) begin
                  form_in = KIND_SEAT;
               end else if (len_ff >= LW'(6) && rd_data == CHAR_P) begin
                  form_in = KIND_ENTRY;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               case (form_ff)
                  KIND_ROOM: begin
                     room_in = {room_ff[11:0], hx[3:0]};
                     if (!hx[4]) begin
                        state_in = ST_IDLE;
                     end else if (idx_ff == 3'd4) begin
                        stat.emit = 1'b1;
                        res.kind  = KIND_ROOM;
                        res.room  = room_in;
                        res.last  = 1'b1;
                        state_in  = ST_IDLE;
                     end
                  end
                  KIND_SEAT: begin
                     state_in = ST_IDLE;
                     if (sok) begin
                        stat.emit = 1'b1;
                        res.kind  = KIND_SEAT;
                        res.seat  = sdiff[2:0];
                        res.last  = 1'b1;
                     end
                  end
                  KIND_ENTRY: begin
                     if (idx_ff == 3'd1) begin
                        seat_in = sdiff[2:0];
                        if (!sok) begin
                           state_in = ST_IDLE;
                        end
                     end else begin
                        room_in = {room_ff[11:0], hx[3:0]};
                        if (!hx[4]) begin
                           state_in = ST_IDLE;
                        end else if (idx_ff == 3'd5) begin
                           cnt_in    = ncount;
                           rd_idx_in = '0;
                           em_idx_in = '0;
                           if (ncount == '0) begin
                              // empty seat: one beat, no name
                              stat.emit = 1'b1;
                              res.kind  = KIND_ENTRY;
                              res.seat  = seat_ff;
                              res.room  = room_in;
                              res.last  = 1'b1;
                              state_in  = ST_IDLE;
                           end else begin
                              state_in = ST_NAME;
                           end
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_NAME: begin
            fire = pending && can_emit;
            if (fire) begin
               stat.emit        = 1'b1;
               res.kind         = KIND_ENTRY;
               res.out_byte     = rd_data;
               res.seat         = seat_ff;
               res.room         = room_ff;
               res.name_present = 1'b1;
               res.last         = (em_idx_ff + CW'(1)) == cnt_ff;
               em_idx_in        = em_idx_ff + CW'(1);
               if (res.last) begin
                  state_in = ST_IDLE;
               end
            end
            // one read in flight; RAM output holds until consumed
            if (rd_idx_ff != cnt_ff && (!pending || fire)) begin
               rd_en     = 1'b1;
               rd_addr   = AW'(rd_idx_ff + CW'(6));
               rd_idx_in = rd_idx_ff + CW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff    <= idx_in;
      form_ff   <= form_in;
      room_ff   <= room_in;
      seat_ff   <= seat_in;
      len_ff    <= len_in;
      cnt_ff    <= cnt_in;
      rd_idx_ff <= rd_idx_in;
      em_idx_ff <= em_idx_in;
   end

endmodule

/* rtl/telnet_oob_frame_deframer.sv */
// ----------------------------------------------------------------------------
// telnet_oob_frame_deframer
// Telnet IAC stripper that pulls out-of-band frames out of the byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one link byte per beat (req_valid / req_stall).
//   rsp_* carries result beats from an output register (rsp_valid / rsp_stall);
//   rsp_last closes the run of beats caused by one link byte.
//   csr_* writes start_marker (0), end_marker (1), drain_limit (2); csr_ready
//   is always high, other indexes are ignored. Write only while idle.
// Timing:
//   The front end takes a plain, IAC or frame data byte whenever req_stall is
//   low; a console byte shows on rsp in the cycle after it is taken. An end
//   marker hands the frame to the decoder, which reads the buffer RAM one
//   byte a cycle: it walks the header, then a seat entry streams one name
//   beat per cycle while rsp is not stalled. The single RAM read port sets
//   this rate; req_stall is high meanwhile.
// Stalls: while rsp holds an untaken beat and rsp_stall is high, req_stall is
//   high and the decoder holds its name walk.
// Reset: synchronous; clears the markers to their defaults and all framing
//   state. The frame buffer needs no clearing: only written entries are used.
// ----------------------------------------------------------------------------
module telnet_oob_frame_deframer #(
   parameter int FRAME_MAX = 32,
   parameter int NAME_MAX  = 16,
   parameter int SEATS     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_seat,
   output logic [15:0] rsp_room,
   output logic        rsp_name_present,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import tofd_pkg::*;

   localparam int LW = $clog2(FRAME_MAX + 1);
   localparam int AW = $clog2(FRAME_MAX);

   // configuration
   logic [7:0]  start_marker_ff;
   logic [7:0]  end_marker_ff;
   logic [15:0] drain_limit_ff;

   // framing state
   logic [1:0]    skip_count_ff, skip_count_in;
   logic          in_frame_ff, in_frame_in;
   logic [LW-1:0] frame_length_ff, frame_length_in;
   logic          frame_overflow_ff, frame_overflow_in;
   logic [15:0]   seen_count_ff, seen_count_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic         accept;
   logic         out_free;
   logic         buf_we;
   logic         dec_start;
   logic         console_emit;
   logic [16:0]  seen_next;
   logic         ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]   ram_rdata;
   dec_stat_type dec_stat;
   result_type   dec_res;

   // output slot is free when empty or its beat leaves this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = dec_stat.busy || !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign seen_next = {1'b0, seen_count_ff} + 17'd1;

   always_comb begin
      skip_count_in     = skip_count_ff;
      in_frame_in       = in_frame_ff;
      frame_length_in   = frame_length_ff;
      frame_overflow_in = frame_overflow_ff;
      seen_count_in     = seen_count_ff;
      buf_we            = 1'b0;
      dec_start         = 1'b0;
      console_emit      = 1'b0;
      if (accept) begin
         if (skip_count_ff != 2'd0) begin
            skip_count_in = skip_count_ff - 2'd1;
         end else if (req_rx_byte == IAC_BYTE) begin
            // IAC plus two option bytes are dropped, inside frames too
            skip_count_in = 2'd2;
         end else if (in_frame_ff) begin
            // end test first, so equal markers close the frame
            if (req_rx_byte == end_marker_ff) begin
               in_frame_in = 1'b0;
               dec_start   = !frame_overflow_ff;
            end else if (seen_next > {1'b0, drain_limit_ff}) begin
               in_frame_in = 1'b0;   // drain limit hit: abandon
            end else begin
               seen_count_in = seen_next[15:0];
               if (!frame_overflow_ff) begin
                  if (frame_length_ff >= LW'(FRAME_MAX)) begin
                     frame_overflow_in = 1'b1;
                  end else begin
                     buf_we          = 1'b1;
                     frame_length_in = frame_length_ff + LW'(1);
                  end
               end
            end
         end else if (req_rx_byte == start_marker_ff) begin
            in_frame_in       = 1'b1;
            frame_length_in   = '0;
            frame_overflow_in = 1'b0;
            seen_count_in     = '0;
         end else begin
            console_emit = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (console_emit) begin
         rsp_in          = '0;
         rsp_in.kind     = KIND_CONSOLE;
         rsp_in.out_byte = req_rx_byte;
         rsp_in.last     = 1'b1;
         rsp_valid_in    = 1'b1;
      end else if (dec_stat.emit) begin
         rsp_in       = dec_res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff   <= 8'd1;
         end_marker_ff     <= 8'd2;
         drain_limit_ff    <= 16'd256;
         skip_count_ff     <= '0;
         in_frame_ff       <= 1'b0;
         frame_length_ff   <= '0;
         frame_overflow_ff <= 1'b0;
         seen_count_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_MARKER: start_marker_ff <= csr_data[7:0];
               CSR_END_MARKER:   end_marker_ff   <= csr_data[7:0];
               CSR_DRAIN_LIMIT:  drain_limit_ff  <= csr_data;
               default: begin
               end
            endcase
         end
         skip_count_ff     <= skip_count_in;
         in_frame_ff       <= in_frame_in;
         frame_length_ff   <= frame_length_in;
         frame_overflow_ff <= frame_overflow_in;
         seen_count_ff     <= seen_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   tofd_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_MAX),
      .AW    (AW)
   ) u_frame_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (frame_length_ff[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tofd_decoder #(
      .FRAME_MAX (FRAME_MAX),
      .NAME_MAX  (NAME_MAX),
      .SEATS     (SEATS),
      .LW        (LW),
      .AW        (AW)
   ) u_decoder (
      .clock    (clock),
      .reset    (reset),
      .start    (dec_start),
      .length   (frame_length_ff),
      .can_emit (out_free),
      .rd_en    (ram_re),
      .rd_addr  (ram_raddr),
      .rd_data  (ram_rdata),
      .stat     (dec_stat),
      .res      (dec_res)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_out_byte     = rsp_ff.out_byte;
   assign rsp_seat         = rsp_ff.seat;
   assign rsp_room         = rsp_ff.room;
   assign rsp_name_present = rsp_ff.name_present;
   assign rsp_last         = rsp_ff.last;

   // assertions
   a_skip_range: assert property (@(posedge clock) disable iff (reset)
      skip_count_ff != 2'd3)
      else $error("IAC skip count out of range");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      frame_length_ff <= LW'(FRAME_MAX))
      else $error("frame length beyond buffer");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      frame_overflow_ff |-> frame_length_ff == LW'(FRAME_MAX))
      else $error("overflow flagged on a partial buffer");

   a_dec_slot: assert property (@(posedge clock) disable iff (reset)
      dec_start |=> !rsp_valid_ff && dec_stat.busy)
      else $error("decoder started with output slot occupied");

endmodule
